FILE: rtl/core/dfm_pkg.sv
package dfm_pkg;

    localparam int MAIN_DEPTH_DEF = 4096;
    localparam int SIDE_DEPTH_DEF = 1024;

    localparam logic [7:0] WRAP_RESET = 8'd80;
    localparam logic [7:0] MARK_BYTE  = 8'h2A;
    localparam logic [7:0] NL_BYTE    = 8'h0A;
    localparam logic [7:0] CR_BYTE    = 8'h0D;

    localparam logic [1:0] CMD_PUSH_MAIN = 2'd0;
    localparam logic [1:0] CMD_PUSH_SIDE = 2'd1;
    localparam logic [1:0] CMD_TX_SLOT   = 2'd2;

    localparam logic [2:0] PH_MAIN  = 3'd0;
    localparam logic [2:0] PH_CHECK = 3'd1;
    localparam logic [2:0] PH_SIDE  = 3'd2;
    localparam logic [2:0] PH_NL    = 3'd3;
    localparam logic [2:0] PH_CR    = 3'd4;

    localparam int          PADDR_W  = 3;
    localparam logic        REG_WRAP = 1'b0;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] data;
    } t_fifo_req;

endpackage

FILE: rtl/core/dfm_in_if.sv
interface dfm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink (input valid, input command, input data_byte, output ready);
endinterface

FILE: rtl/core/dfm_out_if.sv
interface dfm_out_if;
    logic        valid;
    logic        ready;
    logic        send_valid;
    logic [7:0]  send_byte;
    logic [12:0] main_level;
    logic [31:0] main_drops;
    logic [31:0] side_drops;

    modport source (output valid, output send_valid, output send_byte, output main_level,
                    output main_drops, output side_drops, input ready);
    modport sink (input valid, input send_valid, input send_byte, input main_level,
                  input main_drops, input side_drops, output ready);
endinterface

FILE: rtl/core/dual_fifo_debug_tx_merger.sv
// Debug transmit merger: two byte queues feeding one serial transmitter.
// Input channel words carry a command and a byte: push a main byte, push a
// side byte, or offer one transmitter slot. Every accepted word gives exactly
// one result word on the output channel: whether a byte is sent and which one,
// plus the main queue level and both drop counters after that word.
// Side text goes out only at a line start, framed by a '*' marker and a
// newline/carriage return pair, and is wrapped after wrap_length bytes.
// Pushes and slots that do not pop a queue give their result in the cycle
// after acceptance; slots that pop a queue wait in S_WAIT for the registered
// queue RAM read data, and the result is registered from it. The block holds
// one word at a time and takes no new word while a slot waits for that data.
// A result that the receiver has not taken stays in the output register;
// the next word is accepted in the cycle in which that result is taken.
// Reset empties both queues, clears the drop counters, sets wrap_length to 80
// and starts at a line start. Queue RAM contents need no clearing.
// wrap_length is written at APB byte address 0 and read back there.
module dual_fifo_debug_tx_merger #(
    parameter int MAIN_DEPTH = dfm_pkg::MAIN_DEPTH_DEF,
    parameter int SIDE_DEPTH = dfm_pkg::SIDE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dfm_in_if.sink                      i_in,
    dfm_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dfm_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int MAIN_FW = $clog2(MAIN_DEPTH + 1);
    localparam int SIDE_FW = $clog2(SIDE_DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WAIT = 1'b1;

    logic               r_seq, n_seq;
    logic [2:0]         r_phase, n_phase;
    logic [7:0]         r_line_len, n_line_len;
    logic               r_at_end, n_at_end;
    logic               r_pop_side, n_pop_side;
    logic [7:0]         r_wrap;
    logic               r_ov, n_ov;
    logic               r_send_valid, n_send_valid;
    logic [7:0]         r_send_byte, n_send_byte;

    dfm_pkg::t_fifo_req main_req, side_req;
    logic [7:0]         main_rdata, side_rdata;
    logic [MAIN_FW-1:0] main_fill;
    logic [SIDE_FW-1:0] side_fill;
    logic [31:0]        main_drops, side_drops;

    logic               acc;
    logic               cfg_wr;
    logic [7:0]         len_inc;
    logic [7:0]         pop_byte;

    assign acc      = i_in.valid && i_in.ready;
    assign i_in.ready = (r_seq == S_IDLE) && (!r_ov || o_out.ready);
    assign len_inc  = r_line_len + 8'd1;
    assign pop_byte = r_pop_side ? side_rdata : main_rdata;

    always_comb begin
        n_seq        = r_seq;
        n_phase      = r_phase;
        n_line_len   = r_line_len;
        n_at_end     = r_at_end;
        n_pop_side   = r_pop_side;
        n_ov         = r_ov && !o_out.ready;
        n_send_valid = r_send_valid;
        n_send_byte  = r_send_byte;
        main_req     = '0;
        side_req     = '0;
        main_req.data = i_in.data_byte;
        side_req.data = i_in.data_byte;

        if (r_seq == S_WAIT) begin
            // Queue RAM data has arrived for the popping slot.
            n_seq        = S_IDLE;
            n_ov         = 1'b1;
            n_send_valid = 1'b1;
            n_send_byte  = pop_byte;
            if (!r_pop_side) begin
                n_at_end = (pop_byte == dfm_pkg::CR_BYTE);
            end
        end else if (acc) begin
            n_ov         = 1'b1;
            n_send_valid = 1'b0;
            n_send_byte  = 8'd0;
            case (i_in.command)
                dfm_pkg::CMD_PUSH_MAIN: begin
                    main_req.push = 1'b1;
                end
                dfm_pkg::CMD_PUSH_SIDE: begin
                    side_req.push = 1'b1;
                end
                dfm_pkg::CMD_TX_SLOT: begin
                    case (r_phase)
                        dfm_pkg::PH_MAIN: begin
                            if (main_fill != '0) begin
                                main_req.pop = 1'b1;
                                n_pop_side   = 1'b0;
                                n_seq        = S_WAIT;
                                n_ov         = 1'b0;
                            end else begin
                                n_phase = r_at_end ? dfm_pkg::PH_CHECK : dfm_pkg::PH_MAIN;
                            end
                        end
                        dfm_pkg::PH_CHECK: begin
                            if (side_fill != '0) begin
                                n_send_valid = 1'b1;
                                n_send_byte  = dfm_pkg::MARK_BYTE;
                                n_phase      = dfm_pkg::PH_SIDE;
                                n_line_len   = 8'd0;
                            end else begin
                                n_phase = dfm_pkg::PH_MAIN;
                            end
                        end
                        dfm_pkg::PH_SIDE: begin
                            if (side_fill != '0) begin
                                side_req.pop = 1'b1;
                                n_pop_side   = 1'b1;
                                n_seq        = S_WAIT;
                                n_ov         = 1'b0;
                                // A zero wrap length acts as a wrap length of one.
                                if (len_inc >= r_wrap || len_inc == 8'd0) begin
                                    n_line_len = 8'd0;
                                    n_phase    = dfm_pkg::PH_NL;
                                end else begin
                                    n_line_len = len_inc;
                                end
                            end else begin
                                n_phase = dfm_pkg::PH_NL;
                            end
                        end
                        dfm_pkg::PH_NL: begin
                            n_send_valid = 1'b1;
                            n_send_byte  = dfm_pkg::NL_BYTE;
                            n_phase      = dfm_pkg::PH_CR;
                        end
                        dfm_pkg::PH_CR: begin
                            n_send_valid = 1'b1;
                            n_send_byte  = dfm_pkg::CR_BYTE;
                            n_phase      = dfm_pkg::PH_CHECK;
                        end
                        default: begin
                            n_phase = dfm_pkg::PH_CHECK;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq      <= S_IDLE;
            r_phase    <= dfm_pkg::PH_CHECK;
            r_line_len <= 8'd0;
            r_at_end   <= 1'b1;
            r_pop_side <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_seq      <= n_seq;
            r_phase    <= n_phase;
            r_line_len <= n_line_len;
            r_at_end   <= n_at_end;
            r_pop_side <= n_pop_side;
            r_ov       <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_send_valid <= n_send_valid;
        r_send_byte  <= n_send_byte;
    end

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == dfm_pkg::REG_WRAP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap <= dfm_pkg::WRAP_RESET;
        end else if (cfg_wr) begin
            r_wrap <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == dfm_pkg::REG_WRAP) ? {24'd0, r_wrap} : 32'd0;
    assign pready = 1'b1;

    dfm_fifo #(
        .DEPTH (MAIN_DEPTH)
    ) u_main (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (main_req),
        .o_rdata (main_rdata),
        .o_fill  (main_fill),
        .o_drops (main_drops)
    );

    dfm_fifo #(
        .DEPTH (SIDE_DEPTH)
    ) u_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (side_req),
        .o_rdata (side_rdata),
        .o_fill  (side_fill),
        .o_drops (side_drops)
    );

    // Queue state only changes when a word is accepted, so it matches the held result.
    assign o_out.valid      = r_ov;
    assign o_out.send_valid = r_send_valid;
    assign o_out.send_byte  = r_send_byte;
    assign o_out.main_level = 13'(main_fill);
    assign o_out.main_drops = main_drops;
    assign o_out.side_drops = side_drops;

    a_wait_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == S_WAIT) |=> (r_seq == S_IDLE) && r_ov)
        else $error("read wait did not deliver a result");

    a_wait_output_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == S_WAIT) |-> !r_ov)
        else $error("result pending during queue read");

    a_main_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        main_req.pop |-> (main_fill != '0))
        else $error("pop from empty main queue");

    a_side_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        side_req.pop |-> (side_fill != '0))
        else $error("pop from empty side queue");

    a_main_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        main_fill <= MAIN_FW'(MAIN_DEPTH))
        else $error("main queue fill beyond depth");

endmodule

FILE: rtl/core/dfm_ram.sv
module dfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/dfm_fifo.sv
module dfm_fifo #(
    parameter int DEPTH = dfm_pkg::SIDE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dfm_pkg::t_fifo_req         i_req,
    output logic [7:0]                 o_rdata,
    output logic [$clog2(DEPTH+1)-1:0] o_fill,
    output logic [31:0]                o_drops
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [FW-1:0] r_fill, n_fill;
    logic [31:0]   r_drops, n_drops;
    logic          full;
    logic          do_write;

    assign full     = (r_fill == FW'(DEPTH));
    assign do_write = i_req.push && !full;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        n_drops  = r_drops;
        if (i_req.push) begin
            if (full) begin
                n_drops = r_drops + 32'd1;
            end else begin
                n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
                n_fill   = r_fill + 1'b1;
            end
        end else if (i_req.pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            n_fill   = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
            r_drops  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
            r_drops  <= n_drops;
        end
    end

    dfm_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_req.data),
        .i_re    (i_req.pop),
        .i_raddr (r_rd_ptr),
        .o_rdata (o_rdata)
    );

    assign o_fill  = r_fill;
    assign o_drops = r_drops;

endmodule

FILE: test/dfm_tx_checker.sv
`timescale 1ns / 1ps

module dfm_tx_checker #(
    parameter int MAIN_DEPTH = dfm_pkg::MAIN_DEPTH_DEF,
    parameter int SIDE_DEPTH = dfm_pkg::SIDE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dfm_in_if                           i_in,
    dfm_out_if                          i_out,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [dfm_pkg::PADDR_W-1:0] i_paddr,
    input  logic [31:0]                 i_pwdata,
    input  logic                        i_pready,
    output int                          o_failures,
    output int                          o_pending
);

    localparam logic [dfm_pkg::PADDR_W-1:0] WRAP_ADDR = {dfm_pkg::REG_WRAP, 2'b00};

    typedef struct packed {
        logic        send_valid;
        logic [7:0]  send_byte;
        logic [12:0] main_level;
        logic [31:0] main_drops;
        logic [31:0] side_drops;
    } t_tx_word;

    logic [7:0]  main_text[$];
    logic [7:0]  side_text[$];
    logic [31:0] main_drop_cnt;
    logic [31:0] side_drop_cnt;
    logic [2:0]  phase;
    logic [7:0]  side_col;
    logic        line_ended;
    logic [7:0]  wrap_len;
    t_tx_word    tx_expected[$];
    int          fail_cnt;

    task automatic predict_tx_word(input logic [1:0] cmd, input logic [7:0] data);
        t_tx_word w;
        w = '0;
        case (cmd)
            dfm_pkg::CMD_PUSH_MAIN: begin
                if (main_text.size() < MAIN_DEPTH) begin
                    main_text.push_back(data);
                end else begin
                    main_drop_cnt = main_drop_cnt + 32'd1;
                end
            end
            dfm_pkg::CMD_PUSH_SIDE: begin
                if (side_text.size() < SIDE_DEPTH) begin
                    side_text.push_back(data);
                end else begin
                    side_drop_cnt = side_drop_cnt + 32'd1;
                end
            end
            dfm_pkg::CMD_TX_SLOT: begin
                case (phase)
                    dfm_pkg::PH_MAIN: begin
                        if (main_text.size() > 0) begin
                            w.send_valid = 1'b1;
                            w.send_byte  = main_text.pop_front();
                            line_ended   = (w.send_byte == dfm_pkg::CR_BYTE);
                        end else begin
                            // Side text may only cut in after a completed line.
                            phase = line_ended ? dfm_pkg::PH_CHECK : dfm_pkg::PH_MAIN;
                        end
                    end
                    dfm_pkg::PH_CHECK: begin
                        if (side_text.size() > 0) begin
                            w.send_valid = 1'b1;
                            w.send_byte  = dfm_pkg::MARK_BYTE;
                            side_col     = 8'd0;
                            phase        = dfm_pkg::PH_SIDE;
                        end else begin
                            phase = dfm_pkg::PH_MAIN;
                        end
                    end
                    dfm_pkg::PH_SIDE: begin
                        if (side_text.size() > 0) begin
                            w.send_valid = 1'b1;
                            w.send_byte  = side_text.pop_front();
                            side_col     = side_col + 8'd1;
                            // A wrap length of zero ends the line after every byte.
                            if (side_col >= wrap_len || side_col == 8'd0) begin
                                side_col = 8'd0;
                                phase    = dfm_pkg::PH_NL;
                            end
                        end else begin
                            phase = dfm_pkg::PH_NL;
                        end
                    end
                    dfm_pkg::PH_NL: begin
                        w.send_valid = 1'b1;
                        w.send_byte  = dfm_pkg::NL_BYTE;
                        phase        = dfm_pkg::PH_CR;
                    end
                    dfm_pkg::PH_CR: begin
                        w.send_valid = 1'b1;
                        w.send_byte  = dfm_pkg::CR_BYTE;
                        phase        = dfm_pkg::PH_CHECK;
                    end
                    default: begin
                        phase = dfm_pkg::PH_CHECK;
                    end
                endcase
            end
            default: begin
            end
        endcase
        w.main_level = 13'(main_text.size());
        w.main_drops = main_drop_cnt;
        w.side_drops = side_drop_cnt;
        tx_expected.push_back(w);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    task automatic check_tx_word();
        t_tx_word want;
        if (tx_expected.size() == 0) begin
            $display("%0t: result word with none expected, got send_valid %0d byte %0h",
                     $time, i_out.send_valid, i_out.send_byte);
            fail_cnt++;
        end else begin
            want = tx_expected.pop_front();
            compare_field("send_valid", 32'(want.send_valid), 32'(i_out.send_valid));
            compare_field("send_byte", 32'(want.send_byte), 32'(i_out.send_byte));
            compare_field("main_level", 32'(want.main_level), 32'(i_out.main_level));
            compare_field("main_drops", want.main_drops, i_out.main_drops);
            compare_field("side_drops", want.side_drops, i_out.side_drops);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            main_text.delete();
            side_text.delete();
            tx_expected.delete();
            main_drop_cnt = '0;
            side_drop_cnt = '0;
            phase         = dfm_pkg::PH_CHECK;
            side_col      = '0;
            line_ended    = 1'b1;
            wrap_len      = dfm_pkg::WRAP_RESET;
            fail_cnt      = 0;
            o_failures   <= 0;
            o_pending    <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == WRAP_ADDR) begin
                wrap_len = i_pwdata[7:0];
            end
            // The result leaving now always belongs to an older word than the one
            // entering, so it is checked first.
            if (i_out.valid && i_out.ready) begin
                check_tx_word();
            end
            if (i_in.valid && i_in.ready) begin
                predict_tx_word(i_in.command, i_in.data_byte);
            end
            o_failures <= fail_cnt;
            o_pending  <= tx_expected.size();
        end
    end

endmodule

FILE: test/dual_fifo_debug_tx_merger_test.sv
`timescale 1ns / 1ps

module dual_fifo_debug_tx_merger_test;

    localparam int MAIN_DEPTH  = dfm_pkg::MAIN_DEPTH_DEF;
    localparam int SIDE_DEPTH  = dfm_pkg::SIDE_DEPTH_DEF;
    localparam int STALL_LIMIT = 1000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [dfm_pkg::PADDR_W-1:0] WRAP_ADDR = {dfm_pkg::REG_WRAP, 2'b00};

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [dfm_pkg::PADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    int                          failures;
    int                          pending;
    int                          idle_cycles = 0;
    int                          burst_left = 0;
    logic [15:0]                 rx_cycle = '0;
    logic [7:0]                  wrap_now;

    dfm_in_if  in_ch();
    dfm_out_if out_ch();

    dual_fifo_debug_tx_merger #(
        .MAIN_DEPTH(MAIN_DEPTH),
        .SIDE_DEPTH(SIDE_DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dfm_tx_checker #(
        .MAIN_DEPTH(MAIN_DEPTH),
        .SIDE_DEPTH(SIDE_DEPTH)
    ) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_pready   (pready),
        .o_failures (failures),
        .o_pending  (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // The receiver cycles through four moods: always ready, coin flip,
    // a fixed repeating stall pattern, and rare random stalls.
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 16'd1;
        case (rx_cycle[9:8])
            2'd0: out_ch.ready <= 1'b1;
            2'd1: out_ch.ready <= 1'($urandom_range(0, 1));
            2'd2: out_ch.ready <= (rx_cycle % 7) > 2;
            default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [7:0] text_byte();
        return ($urandom_range(0, 7) == 0) ? dfm_pkg::CR_BYTE : 8'($urandom);
    endfunction

    task automatic send_word(input logic [1:0] cmd, input logic [7:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_ch.valid     <= 1'b1;
        in_ch.command   <= cmd;
        in_ch.data_byte <= data;
        burst_left--;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Drains every outstanding result, then rewrites the wrap length.
    task automatic set_wrap(input logic [7:0] val);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WRAP_ADDR;
        pwdata  <= {24'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        wrap_now = val;
    endtask

    // Mostly whole exchanges: some main text, some side text, then at least one
    // slot per pushed byte. The first exchange always overruns the wrap length.
    task automatic run_segment(input int budget);
        int done_cnt;
        int kind;
        int n_main;
        int n_side;
        int n_slot;
        int k;
        logic first;
        logic [1:0] cmd;
        done_cnt = 0;
        first = 1'b1;
        while (done_cnt < budget) begin
            kind = first ? 9 : $urandom_range(0, 9);
            first = 1'b0;
            if (kind < 2) begin
                repeat ($urandom_range(1, 8)) begin
                    cmd = 2'($urandom_range(0, 3));
                    send_word(cmd, 8'($urandom));
                    if (cmd != CMD_UNUSED) begin
                        done_cnt++;
                    end
                end
            end else begin
                n_main = $urandom_range(0, 12);
                n_side = (kind == 9) ? int'(wrap_now) + 2 : $urandom_range(0, 12);
                n_slot = n_main + n_side + $urandom_range(0, 10);
                for (k = 0; k < n_main; k++) begin
                    if (k == n_main - 1 && $urandom_range(0, 3) != 0) begin
                        send_word(dfm_pkg::CMD_PUSH_MAIN, dfm_pkg::CR_BYTE);
                    end else begin
                        send_word(dfm_pkg::CMD_PUSH_MAIN, text_byte());
                    end
                end
                repeat (n_side) send_word(dfm_pkg::CMD_PUSH_SIDE, 8'($urandom));
                for (k = 0; k < n_slot; k++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        send_word(2'($urandom_range(0, 1)), text_byte());
                        done_cnt++;
                    end
                    send_word(dfm_pkg::CMD_TX_SLOT, 8'($urandom));
                end
                done_cnt += n_main + n_side + n_slot;
            end
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.command   <= dfm_pkg::CMD_PUSH_MAIN;
        in_ch.data_byte <= 8'd0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        wrap_now = dfm_pkg::WRAP_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        fork
            begin
                // Line start with nothing queued, then main phase with nothing queued.
                send_word(dfm_pkg::CMD_TX_SLOT, 8'hFF);
                send_word(dfm_pkg::CMD_TX_SLOT, 8'h00);
                send_word(CMD_UNUSED, 8'hFF);
                send_word(dfm_pkg::CMD_PUSH_MAIN, 8'h00);
                send_word(dfm_pkg::CMD_PUSH_MAIN, 8'hFF);
                send_word(dfm_pkg::CMD_PUSH_SIDE, 8'hA5);
                send_word(dfm_pkg::CMD_PUSH_SIDE, 8'h5A);
                // Marker, two side bytes, side queue runs dry, newline, return.
                repeat (6) send_word(dfm_pkg::CMD_TX_SLOT, 8'h00);
                // Empty side check, then both main bytes, then main runs dry
                // without a carriage return behind it.
                repeat (4) send_word(dfm_pkg::CMD_TX_SLOT, 8'h00);
                send_word(dfm_pkg::CMD_PUSH_SIDE, 8'h11);
                send_word(dfm_pkg::CMD_TX_SLOT, 8'h00);
                send_word(dfm_pkg::CMD_PUSH_MAIN, dfm_pkg::CR_BYTE);
                repeat (7) send_word(dfm_pkg::CMD_TX_SLOT, 8'h00);

                run_segment(150);
                set_wrap(8'd1);
                run_segment(150);
                set_wrap(8'd255);
                run_segment(100);
                set_wrap(8'd0);
                run_segment(150);
                set_wrap(8'($urandom_range(2, 12)));
                run_segment(150);

                set_wrap(dfm_pkg::WRAP_RESET);
                run_segment(150);

                in_ch.valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
                repeat (10) @(posedge i_clk);
            end
            begin
                wait (idle_cycles >= STALL_LIMIT);
            end
        join_any

        if (idle_cycles < STALL_LIMIT && failures == 0) begin
            $display("dual_fifo_debug_tx_merger_test OK");
        end else begin
            $display("dual_fifo_debug_tx_merger_test NOT OK");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/dfm_pkg.sv
rtl/core/dfm_in_if.sv
rtl/core/dfm_out_if.sv
rtl/core/dfm_ram.sv
rtl/core/dfm_fifo.sv
rtl/core/dual_fifo_debug_tx_merger.sv
test/dfm_tx_checker.sv
test/dual_fifo_debug_tx_merger_test.sv
